@@ src/scc_pkg.sv @@
// scc_pkg: shared constants, tables and types for the spherical coordinate converter
// no dependencies; used by every module under src except scc_delay
`default_nettype none

package scc_pkg;

    localparam int DEF_CORDIC_ITERATIONS = 16;
    localparam int DEF_FRAC_BITS         = 16;
    localparam int MIN_ITERATIONS        = 8;

    localparam int DATA_W = 32;
    localparam int GUARD  = 12;
    localparam int LEN_W  = 48;
    localparam int MAG_W  = LEN_W - 1;
    localparam int ANG_W  = 36;
    localparam int SC_W   = 34;
    localparam int THR_W  = 16;
    localparam int TDATA_W = 3 * DATA_W;

    localparam logic signed [ANG_W-1:0] Q30_PI      = 36'sd3373259426;
    localparam logic signed [ANG_W-1:0] Q30_HALF_PI = 36'sd1686629713;
    localparam logic signed [ANG_W-1:0] Q30_TWO_PI  = 36'sd6746518852;

    localparam logic [29:0] ATAN_Q30 [30] = '{
        30'd843314856, 30'd497837829, 30'd263043836, 30'd133525158, 30'd67021686,
        30'd33543515, 30'd16775850, 30'd8388437, 30'd4194282, 30'd2097149,
        30'd1048575, 30'd524287, 30'd262143, 30'd131071, 30'd65535, 30'd32767,
        30'd16383, 30'd8191, 30'd4095, 30'd2047, 30'd1023, 30'd511, 30'd255,
        30'd127, 30'd63, 30'd31, 30'd15, 30'd7, 30'd3, 30'd1
    };

    // inverse cordic gain, q30, for 8 .. 30 iterations
    localparam logic [29:0] INV_GAIN_Q30 [23] = '{
        30'd652039507, 30'd652034532, 30'd652033289, 30'd652032978, 30'd652032900,
        30'd652032881, 30'd652032876, 30'd652032874, 30'd652032874, 30'd652032874,
        30'd652032874, 30'd652032874, 30'd652032874, 30'd652032874, 30'd652032874,
        30'd652032874, 30'd652032874, 30'd652032874, 30'd652032874, 30'd652032874,
        30'd652032874, 30'd652032874, 30'd652032874
    };

    typedef enum logic {
        OP_TO_SPHERICAL = 1'b0,
        OP_TO_CARTESIAN = 1'b1
    } scc_op_t;

endpackage

`default_nettype wire

@@ src/scc_delay.sv @@
// scc_delay: enable-gated register line that keeps side data aligned with the pipeline
// no package dependency
`default_nettype none

module scc_delay #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 1
) (
    input  wire              aclk,
    input  wire              ce,
    input  wire  [WIDTH-1:0] din,
    output logic [WIDTH-1:0] dout
);

    generate
        if (DEPTH == 0) begin : g_none
            assign dout = din;
        end else begin : g_line
            logic [WIDTH-1:0] line_reg [DEPTH];
            always_ff @(posedge aclk) begin
                if (ce) begin
                    line_reg[0] <= din;
                    for (int i = 1; i < DEPTH; i++) begin
                        line_reg[i] <= line_reg[i-1];
                    end
                end
            end
            assign dout = line_reg[DEPTH-1];
        end
    endgenerate

endmodule

`default_nettype wire

@@ src/scc_gain.sv @@
// scc_gain: two-stage multiply by the inverse cordic gain, rounded half up
// depends on scc_pkg
`default_nettype none

module scc_gain
    import scc_pkg::*;
#(
    parameter int ITERATIONS = DEF_CORDIC_ITERATIONS
) (
    input  wire              aclk,
    input  wire              ce,
    input  wire  [MAG_W-1:0] mag_in,
    output logic [MAG_W-1:0] mag_out
);

    localparam int LO_W    = 15;
    localparam int HI_W    = MAG_W - LO_W;
    localparam int HIP_W   = HI_W + 30;
    localparam int LOP_W   = LO_W + 30;
    localparam int SUM_W   = HIP_W + LO_W;
    localparam logic [29:0]      K_GAIN = INV_GAIN_Q30[ITERATIONS - MIN_ITERATIONS];
    localparam logic [SUM_W-1:0] HALF   = SUM_W'(1) << 29;

    logic [HIP_W-1:0] hi_prod_reg;
    logic [LOP_W-1:0] lo_prod_reg;
    logic [SUM_W-1:0] sum_next;
    logic [MAG_W-1:0] mag_reg;

    always_ff @(posedge aclk) begin
        if (ce) begin
            hi_prod_reg <= HIP_W'(mag_in[MAG_W-1:LO_W]) * HIP_W'(K_GAIN);
            lo_prod_reg <= LOP_W'(mag_in[LO_W-1:0]) * LOP_W'(K_GAIN);
            mag_reg     <= sum_next[30 +: MAG_W];
        end
    end

    assign sum_next = (SUM_W'(hi_prod_reg) << LO_W) + SUM_W'(lo_prod_reg) + HALF;
    assign mag_out  = mag_reg;

endmodule

`default_nettype wire

@@ src/scc_vector.sv @@
// scc_vector: unrolled vectoring cordic, one micro-rotation per register stage
// depends on scc_pkg; output x carries the cordic gain
`default_nettype none

module scc_vector
    import scc_pkg::*;
#(
    parameter int ITERATIONS = DEF_CORDIC_ITERATIONS
) (
    input  wire                     aclk,
    input  wire                     ce,
    input  wire signed [LEN_W-1:0]  x_in,
    input  wire signed [LEN_W-1:0]  y_in,
    output logic signed [LEN_W-1:0] x_out,
    output logic signed [ANG_W-1:0] ang_out
);

    logic signed [LEN_W-1:0] x_reg   [ITERATIONS+1];
    logic signed [LEN_W-1:0] y_reg   [ITERATIONS+1];
    logic signed [ANG_W-1:0] ang_reg [ITERATIONS+1];

    always_ff @(posedge aclk) begin
        if (ce) begin
            // quarter turn for vectors in the left half plane
            if (!x_in[LEN_W-1]) begin
                x_reg[0]   <= x_in;
                y_reg[0]   <= y_in;
                ang_reg[0] <= '0;
            end else if (!y_in[LEN_W-1]) begin
                x_reg[0]   <= y_in;
                y_reg[0]   <= -x_in;
                ang_reg[0] <= Q30_HALF_PI;
            end else begin
                x_reg[0]   <= -y_in;
                y_reg[0]   <= x_in;
                ang_reg[0] <= -Q30_HALF_PI;
            end
            for (int i = 0; i < ITERATIONS; i++) begin
                if (!y_reg[i][LEN_W-1]) begin
                    x_reg[i+1]   <= x_reg[i] + (y_reg[i] >>> i);
                    y_reg[i+1]   <= y_reg[i] - (x_reg[i] >>> i);
                    ang_reg[i+1] <= ang_reg[i] + ANG_W'(ATAN_Q30[i]);
                end else begin
                    x_reg[i+1]   <= x_reg[i] - (y_reg[i] >>> i);
                    y_reg[i+1]   <= y_reg[i] + (x_reg[i] >>> i);
                    ang_reg[i+1] <= ang_reg[i] - ANG_W'(ATAN_Q30[i]);
                end
            end
        end
    end

    assign x_out   = x_reg[ITERATIONS];
    assign ang_out = ang_reg[ITERATIONS];

endmodule

`default_nettype wire

@@ src/scc_sincos.sv @@
// scc_sincos: angle reduction modulo two pi, half-turn fold and rotation cordic
// depends on scc_pkg; cosine and sine come out in q30
`default_nettype none

module scc_sincos
    import scc_pkg::*;
#(
    parameter int ITERATIONS = DEF_CORDIC_ITERATIONS,
    parameter int FRAC_BITS  = DEF_FRAC_BITS
) (
    input  wire                      aclk,
    input  wire                      ce,
    input  wire signed [DATA_W-1:0]  ang_in,
    output logic signed [DATA_W-1:0] cos_out,
    output logic signed [DATA_W-1:0] sin_out
);

    localparam int ASHIFT = 30 - FRAC_BITS;
    localparam int MW     = DATA_W + ASHIFT;
    localparam logic [MW-1:0] TWO_PI_W = MW'(Q30_TWO_PI);

    logic signed [MW-1:0]    shifted;
    logic [MW-1:0]           mag_reg  [ASHIFT+1];
    logic                    sign_reg [ASHIFT+1];
    logic signed [ANG_W-1:0] rem;
    logic signed [ANG_W-1:0] wrap_next;
    logic signed [ANG_W-1:0] wrap_reg;
    logic signed [ANG_W-1:0] fold_next;
    logic                    flip_next;
    logic signed [SC_W-1:0]  rx_reg    [ITERATIONS+1];
    logic signed [SC_W-1:0]  ry_reg    [ITERATIONS+1];
    logic signed [ANG_W-1:0] ra_reg    [ITERATIONS+1];
    logic                    flip_reg  [ITERATIONS+1];

    assign shifted = {ang_in, {ASHIFT{1'b0}}};

    always_comb begin
        rem = sign_reg[ASHIFT] ? -ANG_W'(mag_reg[ASHIFT]) : ANG_W'(mag_reg[ASHIFT]);
        wrap_next = rem;
        if (rem > Q30_PI) begin
            wrap_next = rem - Q30_TWO_PI;
        end else if (rem < -Q30_PI) begin
            wrap_next = rem + Q30_TWO_PI;
        end
        fold_next = wrap_reg;
        flip_next = 1'b0;
        if (wrap_reg > Q30_HALF_PI) begin
            fold_next = wrap_reg - Q30_PI;
            flip_next = 1'b1;
        end else if (wrap_reg < -Q30_HALF_PI) begin
            fold_next = wrap_reg + Q30_PI;
            flip_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            sign_reg[0] <= ang_in[DATA_W-1];
            mag_reg[0]  <= ang_in[DATA_W-1] ? MW'(-shifted) : MW'(shifted);
            // restoring reduction, one power-of-two multiple of two pi per stage, largest first
            for (int j = 0; j < ASHIFT; j++) begin
                sign_reg[j+1] <= sign_reg[j];
                if (mag_reg[j] >= (TWO_PI_W << (ASHIFT - 1 - j))) begin
                    mag_reg[j+1] <= mag_reg[j] - (TWO_PI_W << (ASHIFT - 1 - j));
                end else begin
                    mag_reg[j+1] <= mag_reg[j];
                end
            end
            wrap_reg    <= wrap_next;
            rx_reg[0]   <= SC_W'(INV_GAIN_Q30[ITERATIONS - MIN_ITERATIONS]);
            ry_reg[0]   <= '0;
            ra_reg[0]   <= fold_next;
            flip_reg[0] <= flip_next;
            for (int i = 0; i < ITERATIONS; i++) begin
                flip_reg[i+1] <= flip_reg[i];
                if (!ra_reg[i][ANG_W-1]) begin
                    rx_reg[i+1] <= rx_reg[i] - (ry_reg[i] >>> i);
                    ry_reg[i+1] <= ry_reg[i] + (rx_reg[i] >>> i);
                    ra_reg[i+1] <= ra_reg[i] - ANG_W'(ATAN_Q30[i]);
                end else begin
                    rx_reg[i+1] <= rx_reg[i] + (ry_reg[i] >>> i);
                    ry_reg[i+1] <= ry_reg[i] - (rx_reg[i] >>> i);
                    ra_reg[i+1] <= ra_reg[i] + ANG_W'(ATAN_Q30[i]);
                end
            end
        end
    end

    assign cos_out = DATA_W'(flip_reg[ITERATIONS] ? -rx_reg[ITERATIONS] : rx_reg[ITERATIONS]);
    assign sin_out = DATA_W'(flip_reg[ITERATIONS] ? -ry_reg[ITERATIONS] : ry_reg[ITERATIONS]);

endmodule

`default_nettype wire

@@ src/spherical_coordinate_converter.sv @@
// spherical_coordinate_converter: cartesian <-> spherical conversion, top level
// depends on scc_pkg, scc_delay, scc_gain, scc_vector, scc_sincos
//
// usage
//   s_ channel: one vector per transfer, s_tuser selects the direction
//   (0 to spherical, 1 to cartesian); m_ channel: one result per transfer.
//   cfg_wr_en/cfg_wr_data write the origin threshold (q16.16 radius at or
//   below which both angles read zero); write it only while the block is idle.
// structure
//   N = CORDIC_ITERATIONS. the forward path is two vectoring cordics of
//   N + 1 stages with gain multipliers; the reverse path is the modulo two pi
//   reduction, one stage per bit of 30 - FRAC_BITS, plus rotation and products.
// throughput
//   one transfer per cycle while the output is not stalled, both paths fully pipelined.
// reset and stall
//   aresetn clears the valid pipeline and the threshold. when m_tready is low
//   with a result waiting, the whole pipeline holds and s_tready drops; it
//   stays high while the output register is empty.
`default_nettype none

module spherical_coordinate_converter
    import scc_pkg::*;
#(
    parameter int CORDIC_ITERATIONS = DEF_CORDIC_ITERATIONS,
    parameter int FRAC_BITS         = DEF_FRAC_BITS
) (
    input  wire                aclk,
    input  wire                aresetn,
    input  wire                s_tvalid,
    output logic               s_tready,
    input  wire  [TDATA_W-1:0] s_tdata,   // in_a, in_b, in_c
    input  wire  [0:0]         s_tuser,   // operation
    output logic               m_tvalid,
    input  wire                m_tready,
    output logic [TDATA_W-1:0] m_tdata,   // out_a, out_b, out_c
    input  wire                cfg_wr_en,
    input  wire  [THR_W-1:0]   cfg_wr_data
);

    localparam int N       = CORDIC_ITERATIONS;
    localparam int ASHIFT  = 30 - FRAC_BITS;
    localparam int FWD_LAT = 2 * N + 7;
    localparam int BWD_LAT = N + ASHIFT + 7;
    localparam int LAT     = (FWD_LAT > BWD_LAT) ? FWD_LAT : BWD_LAT;
    localparam int EXT_W   = LEN_W - DATA_W - GUARD;
    localparam int PROD_W  = 2 * DATA_W;

    localparam logic signed [ANG_W-1:0] ANG_ROUND = ANG_W'(1) <<< (ASHIFT - 1);
    localparam logic signed [ANG_W-1:0] PI_OUT    = (Q30_PI + ANG_ROUND) >>> ASHIFT;
    localparam logic [LEN_W-1:0]        R_ROUND   = LEN_W'(1) << (GUARD - 1);
    localparam logic signed [PROD_W-1:0] P_ROUND  = PROD_W'(1) <<< 29;

    function automatic logic [DATA_W-1:0] sat32(input logic signed [PROD_W-1:0] v);
        logic signed [PROD_W-1:0] hi_lim;
        logic signed [PROD_W-1:0] lo_lim;
        hi_lim = PROD_W'(32'sh7FFF_FFFF);
        lo_lim = -hi_lim - PROD_W'(1);
        if (v > hi_lim) begin
            return 32'h7FFF_FFFF;
        end else if (v < lo_lim) begin
            return 32'h8000_0000;
        end
        return v[DATA_W-1:0];
    endfunction

    logic                     ce;
    logic [LAT-1:0]           valid_reg;
    logic [THR_W-1:0]         thr_reg;
    logic signed [DATA_W-1:0] in_a;
    logic signed [DATA_W-1:0] in_b;
    logic signed [DATA_W-1:0] in_c;

    assign in_a = s_tdata[DATA_W-1:0];
    assign in_b = s_tdata[2*DATA_W-1:DATA_W];
    assign in_c = s_tdata[3*DATA_W-1:2*DATA_W];

    assign ce       = !valid_reg[LAT-1] || m_tready;
    assign s_tready = ce;
    assign m_tvalid = valid_reg[LAT-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
            thr_reg   <= '0;
        end else begin
            if (ce) begin
                valid_reg <= {valid_reg[LAT-2:0], s_tvalid};
            end
            if (cfg_wr_en) begin
                thr_reg <= cfg_wr_data;
            end
        end
    end

    // forward path: cartesian to spherical
    logic signed [LEN_W-1:0] x_ext;
    logic signed [LEN_W-1:0] y_ext;
    logic signed [LEN_W-1:0] z_ext;
    logic signed [LEN_W-1:0] x1;
    logic signed [ANG_W-1:0] phi1;
    logic [MAG_W-1:0]        rho;
    logic signed [LEN_W-1:0] z_dly;
    logic signed [ANG_W-1:0] phi_dly;
    logic signed [LEN_W-1:0] z2;
    logic signed [ANG_W-1:0] theta2;
    logic signed [ANG_W-1:0] theta_dly;
    logic [MAG_W-1:0]        rint;

    assign x_ext = {{EXT_W{in_a[DATA_W-1]}}, in_a, {GUARD{1'b0}}};
    assign y_ext = {{EXT_W{in_b[DATA_W-1]}}, in_b, {GUARD{1'b0}}};
    assign z_ext = {{EXT_W{in_c[DATA_W-1]}}, in_c, {GUARD{1'b0}}};

    scc_vector #(.ITERATIONS(N)) u_vec_xy (
        .aclk(aclk), .ce(ce), .x_in(x_ext), .y_in(y_ext), .x_out(x1), .ang_out(phi1)
    );

    scc_gain #(.ITERATIONS(N)) u_gain_xy (
        .aclk(aclk), .ce(ce),
        .mag_in(x1[LEN_W-1] ? '0 : x1[MAG_W-1:0]), .mag_out(rho)
    );

    scc_delay #(.WIDTH(LEN_W), .DEPTH(N + 3)) u_dly_z (
        .aclk(aclk), .ce(ce), .din(z_ext), .dout(z_dly)
    );

    scc_delay #(.WIDTH(ANG_W), .DEPTH(N + 5)) u_dly_phi (
        .aclk(aclk), .ce(ce), .din(phi1), .dout(phi_dly)
    );

    scc_vector #(.ITERATIONS(N)) u_vec_rz (
        .aclk(aclk), .ce(ce), .x_in(z_dly), .y_in({1'b0, rho}),
        .x_out(z2), .ang_out(theta2)
    );

    scc_gain #(.ITERATIONS(N)) u_gain_rz (
        .aclk(aclk), .ce(ce),
        .mag_in(z2[LEN_W-1] ? '0 : z2[MAG_W-1:0]), .mag_out(rint)
    );

    scc_delay #(.WIDTH(ANG_W), .DEPTH(2)) u_dly_theta (
        .aclk(aclk), .ce(ce), .din(theta2), .dout(theta_dly)
    );

    logic [LEN_W-1:0]        r_sum;
    logic [DATA_W-2:0]       r_sat;
    logic signed [ANG_W-1:0] theta_rnd;
    logic signed [ANG_W-1:0] phi_rnd;
    logic signed [ANG_W-1:0] theta_clip;
    logic signed [ANG_W-1:0] phi_clip;
    logic                    at_origin;
    logic [TDATA_W-1:0]      fwd_reg;
    logic [TDATA_W-1:0]      fwd_out;

    always_comb begin
        r_sum = {1'b0, rint} + R_ROUND;
        if (|r_sum[LEN_W-1:GUARD+DATA_W-1]) begin
            r_sat = '1;
        end else begin
            r_sat = r_sum[GUARD +: DATA_W-1];
        end
        theta_rnd  = (theta_dly + ANG_ROUND) >>> ASHIFT;
        phi_rnd    = (phi_dly + ANG_ROUND) >>> ASHIFT;
        theta_clip = theta_rnd;
        if (theta_rnd < 0) begin
            theta_clip = '0;
        end else if (theta_rnd > PI_OUT) begin
            theta_clip = PI_OUT;
        end
        phi_clip = phi_rnd;
        if (phi_rnd < -PI_OUT) begin
            phi_clip = -PI_OUT;
        end else if (phi_rnd > PI_OUT) begin
            phi_clip = PI_OUT;
        end
        at_origin = ({1'b0, r_sat} <= DATA_W'(thr_reg));
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            fwd_reg <= {at_origin ? '0 : DATA_W'(phi_clip),
                        at_origin ? '0 : DATA_W'(theta_clip),
                        {1'b0, r_sat}};
        end
    end

    scc_delay #(.WIDTH(TDATA_W), .DEPTH(LAT - FWD_LAT)) u_pad_fwd (
        .aclk(aclk), .ce(ce), .din(fwd_reg), .dout(fwd_out)
    );

    // reverse path: spherical to cartesian
    logic signed [DATA_W-1:0] ct;
    logic signed [DATA_W-1:0] st;
    logic signed [DATA_W-1:0] cp;
    logic signed [DATA_W-1:0] sp;
    logic signed [DATA_W-1:0] ct_dly;
    logic signed [DATA_W-1:0] a_dly;
    logic signed [PROD_W-1:0] p_sc_reg;
    logic signed [PROD_W-1:0] p_ss_reg;
    logic signed [DATA_W-1:0] sc_reg;
    logic signed [DATA_W-1:0] ss_reg;
    logic signed [PROD_W-1:0] q_x_reg;
    logic signed [PROD_W-1:0] q_y_reg;
    logic signed [PROD_W-1:0] q_z_reg;
    logic signed [PROD_W-1:0] sc_full;
    logic signed [PROD_W-1:0] ss_full;
    logic [TDATA_W-1:0]       bwd_reg;
    logic [TDATA_W-1:0]       bwd_out;

    scc_sincos #(.ITERATIONS(N), .FRAC_BITS(FRAC_BITS)) u_sc_theta (
        .aclk(aclk), .ce(ce), .ang_in(in_b), .cos_out(ct), .sin_out(st)
    );

    scc_sincos #(.ITERATIONS(N), .FRAC_BITS(FRAC_BITS)) u_sc_phi (
        .aclk(aclk), .ce(ce), .ang_in(in_c), .cos_out(cp), .sin_out(sp)
    );

    scc_delay #(.WIDTH(DATA_W), .DEPTH(N + ASHIFT + 5)) u_dly_a (
        .aclk(aclk), .ce(ce), .din(in_a), .dout(a_dly)
    );

    scc_delay #(.WIDTH(DATA_W), .DEPTH(2)) u_dly_ct (
        .aclk(aclk), .ce(ce), .din(ct), .dout(ct_dly)
    );

    assign sc_full = (p_sc_reg + P_ROUND) >>> 30;
    assign ss_full = (p_ss_reg + P_ROUND) >>> 30;

    always_ff @(posedge aclk) begin
        if (ce) begin
            p_sc_reg <= PROD_W'(st) * PROD_W'(cp);
            p_ss_reg <= PROD_W'(st) * PROD_W'(sp);
            sc_reg   <= DATA_W'(sc_full);
            ss_reg   <= DATA_W'(ss_full);
            q_x_reg  <= PROD_W'(a_dly) * PROD_W'(sc_reg);
            q_y_reg  <= PROD_W'(a_dly) * PROD_W'(ss_reg);
            q_z_reg  <= PROD_W'(a_dly) * PROD_W'(ct_dly);
            bwd_reg  <= {sat32((q_z_reg + P_ROUND) >>> 30),
                         sat32((q_y_reg + P_ROUND) >>> 30),
                         sat32((q_x_reg + P_ROUND) >>> 30)};
        end
    end

    scc_delay #(.WIDTH(TDATA_W), .DEPTH(LAT - BWD_LAT)) u_pad_bwd (
        .aclk(aclk), .ce(ce), .din(bwd_reg), .dout(bwd_out)
    );

    // result select
    logic op_dly;

    scc_delay #(.WIDTH(1), .DEPTH(LAT)) u_dly_op (
        .aclk(aclk), .ce(ce), .din(s_tuser[0]), .dout(op_dly)
    );

    assign m_tdata = (op_dly == OP_TO_CARTESIAN) ? bwd_out : fwd_out;

endmodule

`default_nettype wire

@@ src/scc_assert.sv @@
// scc_assert: port-level checks for the spherical coordinate converter
// depends on scc_pkg; bound to the top level at the end of this file
`default_nettype none

module scc_assert
    import scc_pkg::*;
(
    input wire               aclk,
    input wire               aresetn,
    input wire               s_tready,
    input wire               m_tvalid,
    input wire               m_tready,
    input wire [TDATA_W-1:0] m_tdata
);

    // a stalled result transfer holds its data
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    a_ready_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty output");

    a_ready_drain: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tready |-> s_tready)
        else $error("input stalled while output drains");

endmodule

bind spherical_coordinate_converter scc_assert u_scc_assert (
    .aclk(aclk),
    .aresetn(aresetn),
    .s_tready(s_tready),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata)
);

`default_nettype wire

@@ bench/spherical_coordinate_converter_tb.sv @@
// spherical_coordinate_converter_tb: self-checking bench for the cartesian/spherical converter
// depends on scc_pkg and spherical_coordinate_converter; drives random bursts and stalls
// against a bit-exact cordic predictor
`default_nettype none

module spherical_coordinate_converter_tb;
    import scc_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NITER = DEF_CORDIC_ITERATIONS;
    localparam int FRAC = DEF_FRAC_BITS;
    localparam int ASHIFT = 30 - FRAC;
    localparam int LATENCY = 39;
    localparam int N_RANDOM = 1000;

    typedef struct packed {
        logic signed [31:0] c;
        logic signed [31:0] b;
        logic signed [31:0] a;
    } vec_t;

    typedef struct {
        scc_op_t op;
        vec_t    v;
        bit      known;
        vec_t    res;
    } row_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [TDATA_W-1:0] s_tdata = '0;
    logic [0:0] s_tuser = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [TDATA_W-1:0] m_tdata;
    logic cfg_wr_en = 1'b0;
    logic [THR_W-1:0] cfg_wr_data = '0;

    vec_t expected_vecs[$];
    longint unsigned thresh = 0;
    int errors = 0;
    bit hold_long = 1'b0;
    bit hold_done = 1'b0;
    int hold_cnt = 0;

    always #10 aclk = ~aclk;

    spherical_coordinate_converter uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
    );

    function automatic longint asr(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint rshift(longint v, int s);
        return (v + (longint'(1) << (s - 1))) >>> s;
    endfunction

    function automatic logic [31:0] sat(longint v);
        if (v > 64'sd2147483647) v = 64'sd2147483647;
        if (v < -64'sd2147483648) v = -64'sd2147483648;
        return v[31:0];
    endfunction

    function automatic longint unsigned scale_gain(longint unsigned m);
        longint unsigned k, p;
        k = INV_GAIN_Q30[NITER - MIN_ITERATIONS];
        p = (m & 64'h7fff) * k + (64'd1 << 29);
        return ((m >> 15) * k + (p >> 15)) >> 15;
    endfunction

    function automatic longint vector_angle(inout longint x, inout longint y);
        longint ang, t, dx, dy;
        ang = 0;
        if (x < 0) begin
            if (y >= 0) begin
                t = y; y = -x; x = t; ang = Q30_HALF_PI;
            end else begin
                t = -y; y = x; x = t; ang = -Q30_HALF_PI;
            end
        end
        for (int i = 0; i < NITER; i++) begin
            dx = asr(y, i);
            dy = asr(x, i);
            if (y >= 0) begin
                x += dx; y -= dy; ang += ATAN_Q30[i];
            end else begin
                x -= dx; y += dy; ang -= ATAN_Q30[i];
            end
        end
        return ang;
    endfunction

    task automatic rotate_unit(input longint ang, output longint c, output longint s);
        longint x, y, dx, dy;
        bit flip;
        x = INV_GAIN_Q30[NITER - MIN_ITERATIONS];
        y = 0;
        flip = 0;
        ang = ang % longint'(Q30_TWO_PI);
        if (ang > Q30_PI) ang -= Q30_TWO_PI;
        if (ang < -Q30_PI) ang += Q30_TWO_PI;
        if (ang > Q30_HALF_PI) begin
            ang -= Q30_PI; flip = 1;
        end else if (ang < -Q30_HALF_PI) begin
            ang += Q30_PI; flip = 1;
        end
        for (int i = 0; i < NITER; i++) begin
            dx = asr(y, i);
            dy = asr(x, i);
            if (ang >= 0) begin
                x -= dx; y += dy; ang -= ATAN_Q30[i];
            end else begin
                x += dx; y -= dy; ang += ATAN_Q30[i];
            end
        end
        c = flip ? -x : x;
        s = flip ? -y : y;
    endtask

    task automatic convert(input scc_op_t op, input vec_t v, output vec_t res);
        longint x, y, z, phi, rho, theta, ct, st, cp, sp, sc, ss, pi_out;
        longint unsigned r;
        pi_out = rshift(Q30_PI, ASHIFT);
        if (op == OP_TO_SPHERICAL) begin
            x = longint'(v.a) <<< GUARD;
            y = longint'(v.b) <<< GUARD;
            z = longint'(v.c) <<< GUARD;
            phi = vector_angle(x, y);
            rho = scale_gain(x > 0 ? x : 0);
            theta = vector_angle(z, rho);
            r = (scale_gain(z > 0 ? z : 0) + (64'd1 << (GUARD - 1))) >> GUARD;
            if (r > 64'h7fffffff) r = 64'h7fffffff;
            theta = rshift(theta, ASHIFT);
            phi = rshift(phi, ASHIFT);
            if (theta < 0) theta = 0;
            if (theta > pi_out) theta = pi_out;
            if (phi < -pi_out) phi = -pi_out;
            if (phi > pi_out) phi = pi_out;
            if (r <= thresh) begin
                theta = 0; phi = 0;
            end
            res.a = r[31:0];
            res.b = sat(theta);
            res.c = sat(phi);
        end else begin
            rotate_unit(longint'(v.b) <<< ASHIFT, ct, st);
            rotate_unit(longint'(v.c) <<< ASHIFT, cp, sp);
            sc = rshift(st * cp, 30);
            ss = rshift(st * sp, 30);
            res.a = sat(rshift(longint'(v.a) * sc, 30));
            res.b = sat(rshift(longint'(v.a) * ss, 30));
            res.c = sat(rshift(longint'(v.a) * ct, 30));
        end
    endtask

    task automatic send_vec(input scc_op_t op, input vec_t v, input bit known, input vec_t given);
        vec_t e;
        if (known) e = given;
        else convert(op, v, e);
        expected_vecs.push_back(e);
        s_tvalid <= 1'b1;
        s_tdata <= v;
        s_tuser <= op;
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic drain_and_set(input logic [15:0] value);
        s_tvalid <= 1'b0;
        while (expected_vecs.size() != 0) @(posedge aclk);
        repeat (LATENCY + 5) @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        thresh = value;
        @(posedge aclk);
    endtask

    function automatic logic [31:0] rand_word(int kind);
        case (kind)
            0: return $urandom();
            1: return $urandom_range(0, 400000) - 200000;
            2: return $urandom_range(0, 15) - 7;
            3: return {1'($urandom_range(0, 1)), 31'h7fff_ffff ^ 31'($urandom_range(0, 3))};
            default: return $urandom_range(0, 8000000) - 4000000;
        endcase
    endfunction

    // receiver stall pattern, with one long hold-off counted here
    always @(posedge aclk) begin
        if (hold_long && !hold_done) begin
            hold_done <= 1'b1;
            hold_cnt <= 150;
            m_tready <= 1'b0;
        end else if (hold_cnt > 0) begin
            hold_cnt <= hold_cnt - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(0, 3) != 0);
        end
    end

    always @(posedge aclk) begin
        vec_t got, e;
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata;
            if (expected_vecs.size() == 0) begin
                $display("%0t unexpected transfer actual %h", $realtime, got);
                errors++;
            end else begin
                e = expected_vecs.pop_front();
                if (got.a !== e.a) begin
                    $display("%0t out_a expected %0d actual %0d", $realtime, e.a, got.a);
                    errors++;
                end
                if (got.b !== e.b) begin
                    $display("%0t out_b expected %0d actual %0d", $realtime, e.b, got.b);
                    errors++;
                end
                if (got.c !== e.c) begin
                    $display("%0t out_c expected %0d actual %0d", $realtime, e.c, got.c);
                    errors++;
                end
            end
        end
    end

    initial begin
        #50ms;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin
        row_t rows[$];
        vec_t v, zero;
        scc_op_t op;
        int burst, kind;
        logic [15:0] th_set [4] = '{16'hffff, 16'h0001, 16'h8000, 16'h0000};
        zero = '0;

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed table
        rows.push_back('{OP_TO_SPHERICAL, '{c: 0, b: 0, a: 0}, 1, zero});
        rows.push_back('{OP_TO_CARTESIAN, '{c: 0, b: 0, a: 0}, 1, zero});
        rows.push_back('{OP_TO_CARTESIAN, '{c: 32'h7fffffff, b: 32'h7fffffff, a: 0}, 1, zero});
        rows.push_back('{OP_TO_SPHERICAL, '{c: 32'sh80000000, b: 32'sh80000000,
                                           a: 32'sh80000000}, 0, zero});
        rows.push_back('{OP_TO_SPHERICAL, '{c: 32'h7fffffff, b: 32'h7fffffff,
                                           a: 32'h7fffffff}, 0, zero});
        rows.push_back('{OP_TO_SPHERICAL, '{c: 0, b: 0, a: 32'sh80000000}, 0, zero});
        rows.push_back('{OP_TO_SPHERICAL, '{c: 0, b: 65536, a: -65536}, 0, zero});
        rows.push_back('{OP_TO_SPHERICAL, '{c: 0, b: -65536, a: -65536}, 0, zero});
        rows.push_back('{OP_TO_SPHERICAL, '{c: -65536, b: 0, a: 0}, 0, zero});
        rows.push_back('{OP_TO_SPHERICAL, '{c: 65536, b: 0, a: 0}, 0, zero});
        rows.push_back('{OP_TO_SPHERICAL, '{c: 1, b: 1, a: 1}, 0, zero});
        rows.push_back('{OP_TO_CARTESIAN, '{c: 0, b: 102944, a: 32'h7fffffff}, 0, zero});
        rows.push_back('{OP_TO_CARTESIAN, '{c: 205887, b: 205887, a: 32'sh80000000}, 0, zero});
        rows.push_back('{OP_TO_CARTESIAN, '{c: 32'sh80000000, b: 32'sh80000000,
                                           a: 32'h7fffffff}, 0, zero});
        rows.push_back('{OP_TO_CARTESIAN, '{c: 32'h7fffffff, b: 32'h7fffffff,
                                           a: 32'sh80000000}, 0, zero});
        rows.push_back('{OP_TO_CARTESIAN, '{c: -51472, b: 51472, a: -65536}, 0, zero});
        rows.push_back('{OP_TO_CARTESIAN, '{c: 411774, b: -411774, a: 65536}, 0, zero});
        foreach (rows[i]) send_vec(rows[i].op, rows[i].v, rows[i].known, rows[i].res);

        // random phases over threshold settings
        for (int ph = 0; ph < 4; ph++) begin
            drain_and_set(th_set[ph]);
            for (int n = 0; n < N_RANDOM / 4; ) begin
                burst = $urandom_range(1, 40);
                for (int k = 0; k < burst && n < N_RANDOM / 4; k++, n++) begin
                    kind = $urandom_range(0, 4);
                    op = scc_op_t'($urandom_range(0, 1));
                    v.a = rand_word(kind);
                    v.b = rand_word($urandom_range(0, 4));
                    v.c = rand_word($urandom_range(0, 4));
                    send_vec(op, v, 0, zero);
                end
                s_tvalid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge aclk);
                if (ph == 1 && n > 100 && !hold_long) begin
                    hold_long = 1'b1;
                    for (int k = 0; k < 120; k++) begin
                        v.a = $urandom(); v.b = $urandom(); v.c = $urandom();
                        op = scc_op_t'(k & 1);
                        send_vec(op, v, 0, zero);
                        n++;
                    end
                end
            end
        end

        s_tvalid <= 1'b0;
        while (expected_vecs.size() != 0) @(posedge aclk);
        repeat (LATENCY + 10) @(posedge aclk);
        if (errors == 0) $display("SCOREBOARD CLEAN");
        else $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule

`default_nettype wire
